// ===== design/sopc_pkg.sv =====
// Shared types, constants and the opcode pattern table of the SIMD opcode pattern counter.
package sopc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_PATS = 40;
    localparam int IDX_W = $clog2(NUM_PATS);
    localparam int FIELD_W = 32;
    localparam int IDX_FIELD_W = 6;
    localparam int VB_FIELD_W = 6;
    localparam int CLAMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

    localparam logic [VB_FIELD_W-1:0] VB_SSE = 6'd16;
    localparam logic [VB_FIELD_W-1:0] VB_AVX = 6'd32;
    localparam logic [VB_FIELD_W-1:0] VB_NONE = 6'd0;
    localparam logic [IDX_FIELD_W-1:0] IDX_TOTAL = 6'd0;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       three;
        logic       avx;
    } pat_t;

    typedef struct packed {
        logic       count_en;
        logic       shift_en;
        logic [7:0] cur;
        logic [7:0] w0;
        logic [7:0] w1;
        logic [1:0] fill;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_DRAIN,
        ST_TOTAL
    } state_t;

    localparam pat_t PAT_TABLE [NUM_PATS] = '{
        '{8'h0f, 8'h28, 8'h00, 1'b0, 1'b0}, '{8'h0f, 8'h29, 8'h00, 1'b0, 1'b0},
        '{8'h66, 8'h0f, 8'h28, 1'b1, 1'b0}, '{8'h66, 8'h0f, 8'h29, 1'b1, 1'b0},
        '{8'hf3, 8'h0f, 8'h6f, 1'b1, 1'b0}, '{8'hf3, 8'h0f, 8'h7f, 1'b1, 1'b0},
        '{8'h0f, 8'h58, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h58, 1'b1, 1'b0},
        '{8'h0f, 8'h59, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h59, 1'b1, 1'b0},
        '{8'h0f, 8'h5c, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h5c, 1'b1, 1'b0},
        '{8'h0f, 8'h5d, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h5d, 1'b1, 1'b0},
        '{8'h0f, 8'h5f, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h5f, 1'b1, 1'b0},
        '{8'h0f, 8'hc6, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'hc6, 1'b1, 1'b0},
        '{8'h0f, 8'h76, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'h76, 1'b1, 1'b0},
        '{8'h0f, 8'heb, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'heb, 1'b1, 1'b0},
        '{8'h0f, 8'hdb, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'hdb, 1'b1, 1'b0},
        '{8'h0f, 8'hdf, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'hdf, 1'b1, 1'b0},
        '{8'h0f, 8'hef, 8'h00, 1'b0, 1'b0}, '{8'h66, 8'h0f, 8'hef, 1'b1, 1'b0},
        '{8'hc5, 8'hfc, 8'h58, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'h58, 1'b1, 1'b1},
        '{8'hc5, 8'hfc, 8'h59, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'h59, 1'b1, 1'b1},
        '{8'hc5, 8'hfc, 8'h5c, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'h5c, 1'b1, 1'b1},
        '{8'hc5, 8'hfc, 8'h5d, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'h5d, 1'b1, 1'b1},
        '{8'hc5, 8'hfc, 8'h5f, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'h5f, 1'b1, 1'b1},
        '{8'hc5, 8'hfc, 8'hc6, 1'b1, 1'b1}, '{8'hc5, 8'hfd, 8'hc6, 1'b1, 1'b1}
    };

    function automatic logic [FIELD_W-1:0] clamp_field(input logic [COUNT_WIDTH-1:0] v);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (w > CLAMP_W'({FIELD_W{1'b1}})) begin
            return {FIELD_W{1'b1}};
        end
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== design/simd_opcode_pattern_counter.sv =====
// Top level of the SIMD opcode pattern counter: byte window, cell chain, report sequencer.
// The block takes one code byte per cycle while counting, with no stall of its own. The byte
// marked end_of_section is counted like any other and then starts the report: the 40 counters
// shift out of the cell chain one per cycle unless out_stall holds back a word, a word leaving
// only for each nonzero count, and one total word follows. The input stays stalled through
// the shift, the total word and any wait on out_stall. The counters and the window are
// empty again when the next byte is taken.
module simd_opcode_pattern_counter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            code_byte,
    input  logic                                  end_of_section,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sopc_pkg::IDX_FIELD_W-1:0]      pattern_index,
    output logic [sopc_pkg::FIELD_W-1:0]          match_count,
    output logic [sopc_pkg::VB_FIELD_W-1:0]       vector_bytes,
    output logic                                  is_total,
    output logic                                  report_last
);
    import sopc_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [7:0]             w0_reg;
    logic [7:0]             w0_next;
    logic [7:0]             w1_reg;
    logic [7:0]             w1_next;
    logic [1:0]             fill_reg;
    logic [1:0]             fill_next;
    logic [IDX_W-1:0]       drain_idx_reg;
    logic [IDX_W-1:0]       drain_idx_next;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [IDX_FIELD_W-1:0] idx_next;
    logic [FIELD_W-1:0]     count_reg;
    logic [FIELD_W-1:0]     count_next;
    logic [VB_FIELD_W-1:0]  vb_reg;
    logic [VB_FIELD_W-1:0]  vb_next;
    logic                   total_flag_reg;
    logic                   total_flag_next;

    logic                   in_accept;
    logic                   slot_free;
    logic                   head_nz;
    logic                   advance;
    logic                   load_word;
    logic [COUNT_WIDTH:0]   sum;
    pat_t                   head_pat;
    cell_ctl_t              ctl;
    logic [COUNT_WIDTH-1:0] chain [NUM_PATS+1];

    assign in_stall  = (state_reg != ST_COUNT);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign head_nz   = (chain[0] != '0);
    assign head_pat  = PAT_TABLE[drain_idx_reg];
    assign sum       = {1'b0, total_reg} + {1'b0, chain[0]};

    always_comb
    begin
        ctl.count_en = in_accept;
        ctl.shift_en = advance;
        ctl.cur      = code_byte;
        ctl.w0       = w0_reg;
        ctl.w1       = w1_reg;
        ctl.fill     = fill_reg;
    end

    assign chain[NUM_PATS] = '0;

    for (genvar i = 0; i < NUM_PATS; i++)
    begin : g_cell
        sopc_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .pat    (PAT_TABLE[i]),
            .ctl    (ctl),
            .cnt_in (chain[i+1]),
            .cnt    (chain[i])
        );
    end

    always_comb
    begin
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        fill_next = fill_reg;
        if (in_accept)
        begin
            if (end_of_section)
            begin
                w0_next   = 8'd0;
                w1_next   = 8'd0;
                fill_next = 2'd0;
            end
            else
            begin
                w0_next   = w1_reg;
                w1_next   = code_byte;
                fill_next = fill_reg[1] ? fill_reg : fill_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        drain_idx_next  = drain_idx_reg;
        total_next      = total_reg;
        advance         = 1'b0;
        load_word       = 1'b0;
        idx_next        = idx_reg;
        count_next      = count_reg;
        vb_next         = vb_reg;
        total_flag_next = total_flag_reg;
        case (state_reg)
            ST_COUNT:
            begin
                if (in_accept && end_of_section)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                advance = !head_nz || slot_free;
                if (head_nz && slot_free)
                begin
                    load_word       = 1'b1;
                    idx_next        = IDX_FIELD_W'(drain_idx_reg);
                    count_next      = clamp_field(chain[0]);
                    vb_next         = head_pat.avx ? VB_AVX : VB_SSE;
                    total_flag_next = 1'b0;
                    total_next      = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                       : sum[COUNT_WIDTH-1:0];
                end
                if (advance)
                begin
                    if (drain_idx_reg == IDX_W'(NUM_PATS - 1))
                    begin
                        drain_idx_next = '0;
                        state_next     = ST_TOTAL;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_TOTAL:
            begin
                if (slot_free)
                begin
                    load_word       = 1'b1;
                    idx_next        = IDX_TOTAL;
                    count_next      = clamp_field(total_reg);
                    vb_next         = VB_NONE;
                    total_flag_next = 1'b1;
                    total_next      = '0;
                    state_next      = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_word)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COUNT;
            w0_reg        <= 8'd0;
            w1_reg        <= 8'd0;
            fill_reg      <= 2'd0;
            drain_idx_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            fill_reg      <= fill_next;
            drain_idx_reg <= drain_idx_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        vb_reg         <= vb_next;
        total_flag_reg <= total_flag_next;
    end

    assign out_valid     = out_valid_reg;
    assign pattern_index = idx_reg;
    assign match_count   = count_reg;
    assign vector_bytes  = vb_reg;
    assign is_total      = total_flag_reg;
    assign report_last   = total_flag_reg;

`ifndef NO_ASSERTIONS
    a_end_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_section) |=> (state_reg == ST_DRAIN))
        else $error("end of section did not start the report");

    a_cleared_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TOTAL && slot_free) |=>
        (chain[0] == '0 && chain[NUM_PATS-1] == '0 && total_reg == '0))
        else $error("counters not cleared after the report");

    a_pattern_word_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_total) |-> (match_count != '0))
        else $error("pattern word carries a zero count");

    a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |-> (drain_idx_reg == '0))
        else $error("drain index not at zero while counting");
`endif

endmodule

// ===== design/sopc_cell.sv =====
// One counter cell: matches its pattern against the byte window and shifts its count along the chain.
module sopc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sopc_pkg::pat_t                   pat,
    input  sopc_pkg::cell_ctl_t              ctl,
    input  logic [sopc_pkg::COUNT_WIDTH-1:0] cnt_in,
    output logic [sopc_pkg::COUNT_WIDTH-1:0] cnt
);
    import sopc_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   hit;

    always_comb
    begin
        if (pat.three)
        begin
            hit = ctl.fill[1] && (ctl.w0 == pat.b0) && (ctl.w1 == pat.b1)
                  && (ctl.cur == pat.b2);
        end
        else
        begin
            hit = (ctl.fill != 2'd0) && (ctl.w1 == pat.b0) && (ctl.cur == pat.b1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.shift_en)
        begin
            cnt_next = cnt_in;
        end
        else if (ctl.count_en && hit && (cnt_reg != {COUNT_WIDTH{1'b1}}))
        begin
            cnt_next = cnt_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

// ===== verif/simd_opcode_pattern_counter_tb.sv =====
// Self-checking testbench of the SIMD opcode pattern counter: byte stimulus, report prediction and checking.
module simd_opcode_pattern_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PATS = sopc_pkg::NUM_PATS;
    localparam int HOLD_LEN = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_BYTES = 97;

    // Two-byte entries are the ones that start with 0F; every other entry is three bytes long.
    localparam logic [23:0] OPCODE_SEQS [NUM_PATS] = '{
        24'h0f2800, 24'h0f2900, 24'h660f28, 24'h660f29, 24'hf30f6f, 24'hf30f7f,
        24'h0f5800, 24'h660f58, 24'h0f5900, 24'h660f59, 24'h0f5c00, 24'h660f5c,
        24'h0f5d00, 24'h660f5d, 24'h0f5f00, 24'h660f5f, 24'h0fc600, 24'h660fc6,
        24'h0f7600, 24'h660f76, 24'h0feb00, 24'h660feb, 24'h0fdb00, 24'h660fdb,
        24'h0fdf00, 24'h660fdf, 24'h0fef00, 24'h660fef,
        24'hc5fc58, 24'hc5fd58, 24'hc5fc59, 24'hc5fd59, 24'hc5fc5c, 24'hc5fd5c,
        24'hc5fc5d, 24'hc5fd5d, 24'hc5fc5f, 24'hc5fd5f, 24'hc5fcc6, 24'hc5fdc6
    };

    typedef struct packed {
        logic [sopc_pkg::IDX_FIELD_W-1:0] pat_idx;
        logic [sopc_pkg::FIELD_W-1:0]     count;
        logic [sopc_pkg::VB_FIELD_W-1:0]  vbytes;
        logic                             total_word;
        logic                             last_word;
    } report_word_t;

    class opcode_count_board;
        logic [7:0]   older_byte;
        logic [7:0]   newer_byte;
        int unsigned  fill;
        logic [31:0]  counts [NUM_PATS];
        report_word_t pending_words [$];
        int unsigned  errors;
        int unsigned  words_checked;
        int unsigned  pattern_words;
        int unsigned  sections;

        function new();
            clear();
            errors = 0;
            words_checked = 0;
            pattern_words = 0;
            sections = 0;
        endfunction

        function void clear();
            older_byte = 8'h00;
            newer_byte = 8'h00;
            fill = 0;
            foreach (counts[i])
                counts[i] = 32'd0;
        endfunction

        function void note_byte(input logic [7:0] value, input logic last_byte);
            logic [23:0]  seq;
            logic         hit;
            logic [31:0]  total;
            report_word_t w;
            for (int i = 0; i < NUM_PATS; i++)
            begin
                seq = OPCODE_SEQS[i];
                if (seq[23:16] == 8'h0f)
                    hit = (fill >= 1) && (newer_byte == seq[23:16]) && (value == seq[15:8]);
                else
                    hit = (fill >= 2) && (older_byte == seq[23:16]) &&
                          (newer_byte == seq[15:8]) && (value == seq[7:0]);
                if (hit && counts[i] != 32'hffff_ffff)
                    counts[i]++;
            end
            older_byte = newer_byte;
            newer_byte = value;
            if (fill < 2)
                fill++;
            if (last_byte)
            begin
                total = 32'd0;
                for (int i = 0; i < NUM_PATS; i++)
                begin
                    if (counts[i] != 32'd0)
                    begin
                        w.pat_idx = sopc_pkg::IDX_FIELD_W'(i);
                        w.count = counts[i];
                        w.vbytes = (i < 28) ? sopc_pkg::VB_SSE : sopc_pkg::VB_AVX;
                        w.total_word = 1'b0;
                        w.last_word = 1'b0;
                        pending_words.push_back(w);
                        pattern_words++;
                        if (32'hffff_ffff - total < counts[i])
                            total = 32'hffff_ffff;
                        else
                            total = total + counts[i];
                    end
                end
                w.pat_idx = sopc_pkg::IDX_TOTAL;
                w.count = total;
                w.vbytes = sopc_pkg::VB_NONE;
                w.total_word = 1'b1;
                w.last_word = 1'b1;
                pending_words.push_back(w);
                sections++;
                clear();
            end
        endfunction

        function void check_word(input report_word_t got);
            report_word_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected report word: pattern_index %0d, match_count %0d",
                       got.pat_idx, got.count);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.pat_idx !== want.pat_idx)
            begin
                $error("pattern_index: expected %0d, got %0d", want.pat_idx, got.pat_idx);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("match_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.vbytes !== want.vbytes)
            begin
                $error("vector_bytes: expected %0d, got %0d", want.vbytes, got.vbytes);
                errors++;
            end
            if (got.total_word !== want.total_word)
            begin
                $error("is_total: expected %0b, got %0b", want.total_word, got.total_word);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("report_last: expected %0b, got %0b", want.last_word, got.last_word);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction

        function void close_out();
            if (pending_words.size() != 0)
            begin
                $error("%0d expected report words never arrived", pending_words.size());
                errors++;
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [7:0]                         code_byte = 8'h00;
    logic                               end_of_section = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [sopc_pkg::IDX_FIELD_W-1:0]   pattern_index;
    logic [sopc_pkg::FIELD_W-1:0]       match_count;
    logic [sopc_pkg::VB_FIELD_W-1:0]    vector_bytes;
    logic                               is_total;
    logic                               report_last;

    opcode_count_board board = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_token = 0;
    int unsigned hold_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int unsigned bytes_sent = 0;

    simd_opcode_pattern_counter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .code_byte      (code_byte),
        .end_of_section (end_of_section),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pattern_index  (pattern_index),
        .match_count    (match_count),
        .vector_bytes   (vector_bytes),
        .is_total       (is_total),
        .report_last    (report_last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_byte(code_byte, end_of_section);
        if (rst_n && out_valid && !out_stall)
            board.check_word('{pattern_index, match_count, vector_bytes, is_total, report_last});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (hold_served != hold_token)
        begin
            hold_served <= hold_token;
            hold_left <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < STALL_LIMIT);
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic last_byte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= value;
        end_of_section <= last_byte;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_pattern(input int idx, input logic last_byte);
        logic [23:0] seq;
        seq = OPCODE_SEQS[idx];
        send_byte(seq[23:16], 1'b0);
        if (seq[23:16] == 8'h0f)
            send_byte(seq[15:8], last_byte);
        else
        begin
            send_byte(seq[15:8], 1'b0);
            send_byte(seq[7:0], last_byte);
        end
    endtask

    task automatic send_random_section();
        logic [7:0]  sect [$];
        logic [23:0] seq;
        int          len;
        int          pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        while (sect.size() < len)
        begin
            pick = $urandom_range(99);
            seq = OPCODE_SEQS[$urandom_range(NUM_PATS - 1)];
            if (pick < 60)
            begin
                sect.push_back(seq[23:16]);
                sect.push_back(seq[15:8]);
                if (seq[23:16] != 8'h0f)
                    sect.push_back(seq[7:0]);
            end
            else if (pick < 80)
                sect.push_back(seq[8 * $urandom_range(2) +: 8]);
            else
                sect.push_back(8'($urandom_range(255)));
        end
        foreach (sect[k])
            send_byte(sect[k], k == sect.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned phase_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h0f, 1'b1);
        send_byte(8'h28, 1'b1);
        send_pattern(0, 1'b1);
        send_pattern(2, 1'b1);
        send_pattern(39, 1'b1);
        send_pattern(27, 1'b0);
        send_pattern(26, 1'b1);
        send_pattern(4, 1'b0);
        send_pattern(28, 1'b0);
        send_byte(8'hff, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct <= (phase == 1) ? 84 : (phase == 3) ? 29 : 0;
            recv_stall_pct <= (phase == 2) ? 84 : (phase == 3) ? 29 : 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (phase == 0 && bytes_sent - phase_start > 10 && hold_token == 0)
                    hold_token <= hold_token + 1;
                send_random_section();
            end
            wait_drained();
        end

        recv_stall_pct <= 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        board.close_out();
        $display("Covered %0d sections of %0d bytes under four idling mixes and one long hold.",
                 board.sections, bytes_sent);
        $display("Checked %0d report words, %0d of them pattern counts.",
                 board.words_checked, board.pattern_words);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
